>>> sv/positional_sequence_store_core_defines.svh
// Assertion macros shared by the positional sequence store RTL.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pss_pkg.sv
// Shared types and constants for the positional sequence store.
// Depends on nothing; used by the cell, the chain and the top level.
package pss_pkg;

    localparam int POS_W      = 5;
    localparam int VAL_IN_W   = 32;
    localparam int VAL_OUT_W  = 32;
    localparam int COUNT_W    = 5;
    localparam int IDX_W      = 9;
    localparam int CAPACITY_D = 16;
    localparam int VALUE_W_D  = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [POS_W-1:0]    position;
        logic [VAL_IN_W-1:0] value_in;
    } t_in_req;

    typedef struct packed {
        logic [VAL_OUT_W-1:0] value_out;
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_out_req;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] position;
    } t_cell_ctl;

endpackage

>>> sv/positional_sequence_store_core.sv
// Positional sequence store: insert, remove, read and clear on an ordered list.
// An accepted request's result is in the output register in the next cycle. Throughput
// is one request per cycle unless stalled; every cell of the chain updates in that cycle.
// A new request is taken whenever the output register is empty or is being emptied.
// Synchronous active-low reset empties the list and the output register; cell data
// is not cleared and is only ever read after it has been written.
module positional_sequence_store_core #(
    parameter int CAPACITY    = pss_pkg::CAPACITY_D,
    parameter int VALUE_WIDTH = pss_pkg::VALUE_W_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pss_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pss_pkg::t_out_req o_out
);
    import pss_pkg::*;

    `include "positional_sequence_store_core_defines.svh"

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = (IW > POS_W) ? IW : POS_W;
    localparam int VW = (VALUE_WIDTH > VAL_IN_W) ? VALUE_WIDTH : VAL_IN_W;
    localparam logic [IW-1:0] Cap = IW'(CAPACITY);

    logic                   r_out_valid;
    t_out_req               r_out;
    logic [IW-1:0]          r_count;
    logic [IW-1:0]          n_count;
    t_status                w_status;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_ins_val;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic [CW-1:0]          w_pos;
    logic [CW-1:0]          w_cnt;
    logic                   w_accept;
    t_cell_ctl              w_ctl;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_pos       = CW'(i_in.position);
    assign w_cnt       = CW'(r_count);
    assign w_ins_val   = VALUE_WIDTH'(VW'(i_in.value_in));

    always_comb begin
        w_status     = ST_OK;
        n_count      = r_count;
        w_value      = '0;
        w_ctl.ins    = 1'b0;
        w_ctl.rem    = 1'b0;
        w_ctl.position = i_in.position;
        unique case (i_in.op)
            OP_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (r_count == Cap) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + IW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.rem = w_accept;
                    w_value   = w_rd_val;
                    n_count   = r_count - IW'(1);
                end
            end
            OP_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_value = w_rd_val;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    pss_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_ins_val (w_ins_val),
        .o_rd_val  (w_rd_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.value_out <= VAL_OUT_W'(VW'(w_value));
            r_out.status    <= w_status;
            r_out.count     <= COUNT_W'(CW'(n_count));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PSS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n,
        1'b1, r_count <= Cap, "count above capacity")
    `PSS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_accept && i_in.op == OP_CLEAR, r_count == '0, "clear left entries")
    `PSS_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n,
        w_accept, r_out_valid, "accepted request gave no result")
    `PSS_ASSERT_SAME(a_full_status, i_clk, i_rst_n,
        r_out_valid && r_out.status == ST_FULL, r_count == Cap, "full status with room left")
    `PSS_ASSERT_SAME(a_error_zero, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_OK, r_out.value_out == '0, "error result carries a value")

endmodule

>>> sv/pss_cell.sv
// One storage cell of the positional sequence store chain.
// Depends on pss_pkg; shifts towards either neighbour on insert or remove.
module pss_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  pss_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic [VALUE_WIDTH-1:0] i_ins_val,
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic [VALUE_WIDTH-1:0] o_rd_val
);
    import pss_pkg::*;

    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic [IDX_W-1:0]       w_pos;

    assign w_pos = IDX_W'(i_ctl.position);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (CellIdx > w_pos) begin
                n_val = i_left;
            end else if (CellIdx == w_pos) begin
                n_val = i_ins_val;
            end
        end else if (i_ctl.rem) begin
            if (CellIdx >= w_pos) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val    = r_val;
    assign o_rd_val = (CellIdx == w_pos) ? r_val : '0;

endmodule

>>> sv/pss_chain.sv
// Row of storage cells for the positional sequence store.
// Depends on pss_pkg and pss_cell; merges the selected cell onto one read bus.
module pss_chain #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  pss_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_ins_val,
    output logic [VALUE_WIDTH-1:0] o_rd_val
);
    import pss_pkg::*;

    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_rd  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ins_val;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        pss_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_ins_val (i_ins_val),
            .o_val     (w_val[g]),
            .o_rd_val  (w_rd[g])
        );
    end

    always_comb begin
        o_rd_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_rd_val = o_rd_val | w_rd[k];
        end
    end

endmodule
